@@ sv/vramp_pkg.sv @@
// ----------------------------------------------------------------------------
// vramp_pkg
// Shared types and constants of the video RAM address/data port: command
// codes, register map, store sizes and the request bundle sent to the stores.
// ----------------------------------------------------------------------------
package vramp_pkg;

   localparam int PATTERN_BYTES   = 8192;
   localparam int NAMETABLE_BYTES = 2048;
   localparam int PAT_ADDR_W      = $clog2(PATTERN_BYTES);
   localparam int NT_ADDR_W       = $clog2(NAMETABLE_BYTES);

   localparam int VADDR_W = 16;
   localparam int DATA_W  = 8;

   // Address steps after a data access.
   localparam logic [VADDR_W-1:0] STEP_COLUMN = 16'd1;
   localparam logic [VADDR_W-1:0] STEP_ROW    = 16'd32;

   // Address writes first clear the two top bits of the video address.
   localparam logic [VADDR_W-1:0] VADDR_MASK = 16'h3fff;

   // Top nibble of a nametable address (0x2000..0x2FFF).
   localparam logic [3:0] NT_TOP_NIBBLE = 4'h2;

   // Bit of the control byte that selects the row step.
   localparam int CTRL_STEP_BIT = 2;

   // Register map: one register, mirroring mode, at byte address 0.
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MIRRORING = 1'b0;

   typedef enum logic [1:0] {
      FUNC_CONTROL = 2'd0,
      FUNC_ADDRESS = 2'd1,
      FUNC_WRITE   = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   // One access to the video stores.
   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic               horizontal;
      logic [VADDR_W-1:0] addr;
      logic [DATA_W-1:0]  wdata;
   } mem_req_type;

endpackage

@@ sv/vramp_ram.sv @@
// ----------------------------------------------------------------------------
// vramp_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vramp_ram #(
   parameter int ADDR_W = 10,
   parameter int WORD_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WORD_W-1:0] wdata,
   output logic [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] mem [0:(1<<ADDR_W)-1];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/vramp_mem.sv @@
// ----------------------------------------------------------------------------
// vramp_mem
// Video address decoder with the pattern store and the mirrored nametable
// store. Reads return in the cycle after the request; unmapped reads return 0.
// ----------------------------------------------------------------------------
module vramp_mem (
   input  logic                          clock,
   input  vramp_pkg::mem_req_type        req,
   output logic [vramp_pkg::DATA_W-1:0]  rd_data
);

   logic                              hit_pat;
   logic                              hit_nt;
   logic                              nt_half;
   logic [vramp_pkg::PAT_ADDR_W-1:0]  pat_idx;
   logic [vramp_pkg::NT_ADDR_W-1:0]   nt_idx;
   logic [vramp_pkg::DATA_W-1:0]      pat_q;
   logic [vramp_pkg::DATA_W-1:0]      nt_q;
   logic                              sel_pat_ff;
   logic                              sel_nt_ff;

   always_comb begin
      hit_pat = (req.addr[vramp_pkg::VADDR_W-1:vramp_pkg::PAT_ADDR_W] == '0);
      hit_nt  = (req.addr[vramp_pkg::VADDR_W-1:vramp_pkg::VADDR_W-4]
                 == vramp_pkg::NT_TOP_NIBBLE);
      pat_idx = req.addr[vramp_pkg::PAT_ADDR_W-1:0];
      // Vertical mirroring picks the half with bit 10, horizontal with bit 11.
      nt_half = req.horizontal ? req.addr[11] : req.addr[10];
      nt_idx  = {nt_half, req.addr[vramp_pkg::NT_ADDR_W-2:0]};
   end

   vramp_ram #(
      .ADDR_W (vramp_pkg::PAT_ADDR_W),
      .WORD_W (vramp_pkg::DATA_W)
   ) u_pattern (
      .clock (clock),
      .wr_en (req.wr_en & hit_pat),
      .rd_en (req.rd_en & hit_pat),
      .addr  (pat_idx),
      .wdata (req.wdata),
      .rdata (pat_q)
   );

   vramp_ram #(
      .ADDR_W (vramp_pkg::NT_ADDR_W),
      .WORD_W (vramp_pkg::DATA_W)
   ) u_nametable (
      .clock (clock),
      .wr_en (req.wr_en & hit_nt),
      .rd_en (req.rd_en & hit_nt),
      .addr  (nt_idx),
      .wdata (req.wdata),
      .rdata (nt_q)
   );

   // Remember which store answers the pending read.
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         sel_pat_ff <= hit_pat;
         sel_nt_ff  <= hit_nt;
      end
   end

   always_comb begin
      if (sel_pat_ff) begin
         rd_data = pat_q;
      end else if (sel_nt_ff) begin
         rd_data = nt_q;
      end else begin
         rd_data = '0;
      end
   end

endmodule

@@ sv/video_ram_address_data_port.sv @@
// ----------------------------------------------------------------------------
// video_ram_address_data_port
// CPU-side video RAM port: address latch, increment select and data access
// to a local pattern store and a mirrored 2 KiB nametable.
// ----------------------------------------------------------------------------
// Usage. The CPU sends one beat per register access on the req_ channel:
// req_func selects a control write, an address write, a data write or a data
// read, and req_data carries the written byte. Every request beat produces
// exactly one beat on the rsp_ channel with the byte read (0 unless the
// request was a data read) and the video address after the access.
// For control, address and data-write requests the response is registered
// at the same edge that accepts the request. A data read waits in the read
// state for the byte from the synchronous stores, so the block accepts at
// most one beat per cycle and takes no new request while a read waits.
// Requests are handled one at a time, so a write is always in the store
// before any later read reaches it. The response sits in an output register.
// While the receiver stalls, that beat holds and a new request is accepted
// only in the cycle in which the held beat is taken. Reset clears the address
// to 0, arms the latch for the high byte, selects the column step and sets
// vertical mirroring; the store contents are undefined until written. The
// mirroring register sits on the APB-style port at byte address 0. The user
// must write it only while the block idles; the block does not enforce it.
// ----------------------------------------------------------------------------
module video_ram_address_data_port (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [vramp_pkg::DATA_W-1:0]         req_data,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [vramp_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [vramp_pkg::VADDR_W-1:0]        rsp_current_address,

   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [vramp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   // Two states: idle (taking requests) and waiting for store read data.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [vramp_pkg::VADDR_W-1:0]      video_address_ff, video_address_in;
   logic                               high_byte_next_ff, high_byte_next_in;
   logic                               step_by_row_ff, step_by_row_in;
   logic                               mirroring_ff, mirroring_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [vramp_pkg::DATA_W-1:0]       rsp_read_data_ff, rsp_read_data_in;
   logic [vramp_pkg::VADDR_W-1:0]      rsp_address_ff, rsp_address_in;

   logic                               req_fire;
   logic                               csr_write;
   vramp_pkg::func_type                func;
   logic [vramp_pkg::VADDR_W-1:0]      masked_address;
   logic [vramp_pkg::VADDR_W-1:0]      step;
   vramp_pkg::mem_req_type             mem_req;
   logic [vramp_pkg::DATA_W-1:0]       mem_rd_data;

   // ---------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is
   // tied high so every transfer finishes without wait states.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      mirroring_in = mirroring_ff;
      if (csr_write && (paddr[2] == vramp_pkg::CSR_IDX_MIRRORING)) begin
         mirroring_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == vramp_pkg::CSR_IDX_MIRRORING) begin
         prdata = {31'd0, mirroring_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Request handling. A request is taken only when idle and when the
   // output register is empty or being emptied in this cycle.
   // ---------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid & req_ready;
   assign func      = vramp_pkg::func_type'(req_func);

   assign masked_address = video_address_ff & vramp_pkg::VADDR_MASK;
   assign step = step_by_row_ff ? vramp_pkg::STEP_ROW : vramp_pkg::STEP_COLUMN;

   always_comb begin
      state_in          = state_ff;
      video_address_in  = video_address_ff;
      high_byte_next_in = high_byte_next_ff;
      step_by_row_in    = step_by_row_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_read_data_in  = rsp_read_data_ff;
      rsp_address_in    = rsp_address_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (func)
                  vramp_pkg::FUNC_CONTROL: begin
                     step_by_row_in = req_data[vramp_pkg::CTRL_STEP_BIT];
                  end
                  vramp_pkg::FUNC_ADDRESS: begin
                     // The high byte may push the address past 14 bits; the
                     // next address write masks it again.
                     if (high_byte_next_ff) begin
                        video_address_in = {req_data, masked_address[7:0]};
                     end else begin
                        video_address_in = {masked_address[15:8], req_data};
                     end
                     high_byte_next_in = ~high_byte_next_ff;
                  end
                  vramp_pkg::FUNC_WRITE: begin
                     video_address_in = video_address_ff + step;
                  end
                  vramp_pkg::FUNC_READ: begin
                     video_address_in = video_address_ff + step;
                  end
                  default: begin
                     video_address_in = video_address_ff;
                  end
               endcase

               if (func == vramp_pkg::FUNC_READ) begin
                  // The byte arrives next cycle; the response waits for it.
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in     = 1'b1;
                  rsp_read_data_in = '0;
                  rsp_address_in   = video_address_in;
               end
            end
         end
         ST_READ: begin
            // The output register is empty here: it was free or being
            // drained when the read was taken.
            rsp_valid_in     = 1'b1;
            rsp_read_data_in = mem_rd_data;
            rsp_address_in   = video_address_ff;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store access uses the address before the step.
   always_comb begin
      mem_req.rd_en      = req_fire && (func == vramp_pkg::FUNC_READ);
      mem_req.wr_en      = req_fire && (func == vramp_pkg::FUNC_WRITE);
      mem_req.horizontal = mirroring_ff;
      mem_req.addr       = video_address_ff;
      mem_req.wdata      = req_data;
   end

   vramp_mem u_mem (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         video_address_ff  <= '0;
         high_byte_next_ff <= 1'b1;
         step_by_row_ff    <= 1'b0;
         mirroring_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         video_address_ff  <= video_address_in;
         high_byte_next_ff <= high_byte_next_in;
         step_by_row_ff    <= step_by_row_in;
         mirroring_ff      <= mirroring_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_address_ff   <= rsp_address_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_current_address = rsp_address_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // While a read is in flight the output register must be empty, otherwise
   // the read data would overwrite a beat that was not taken.
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("read in flight while a response beat is still held");

   // An accepted data read moves to the wait state in the next cycle.
   a_read_waits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (func == vramp_pkg::FUNC_READ)) |=> (state_ff == ST_READ))
      else $error("data read did not wait for the store");

   // A low-byte address write always leaves a 14-bit address.
   a_low_byte_masks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (func == vramp_pkg::FUNC_ADDRESS) && !high_byte_next_ff)
      |=> (video_address_ff[15:14] == 2'b00))
      else $error("address above 14 bits after a low-byte write");

   // Non-read requests put their beat in the output register at once.
   a_direct_response: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (func != vramp_pkg::FUNC_READ)) |=> rsp_valid_ff)
      else $error("missing response beat for a non-read request");

endmodule

@@ tb/video_ram_address_data_port_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_ram_address_data_port_test
// Self-checking bench for the CPU-side video RAM port. A scoreboard class
// keeps its own copy of the video address, the address latch, the step
// select, the mirroring mode and both stores. It predicts every response beat
// from the accepted request beats. Plain tasks drive requests and the APB-style
// register port. Directed beats come first, then four random phases with
// different idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module video_ram_address_data_port_test;

   // Byte address of the mirroring register on the APB-style port.
   localparam logic [vramp_pkg::CSR_ADDR_W-1:0] MIRROR_ADDR =
      vramp_pkg::CSR_ADDR_W'(4 * vramp_pkg::CSR_IDX_MIRRORING);

   localparam int PHASE_BEATS       = 320;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES     = 4;
   localparam int DRAIN_CYCLES      = 10;
   localparam int TIMEOUT_NS        = 2_000_000;

   // The three ways a video address can decode.
   typedef enum int {
      REGION_PATTERN,
      REGION_NAMETABLE,
      REGION_UNMAPPED
   } region_type;

   // One response beat as the port should deliver it.
   typedef struct packed {
      logic [vramp_pkg::DATA_W-1:0]  read_data;
      logic [vramp_pkg::VADDR_W-1:0] address;
   } port_beat_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow state of the port, its stores, and the queue of
   // response beats still owed by the block.
   // -------------------------------------------------------------------------
   class vram_port_scoreboard;
      logic [vramp_pkg::VADDR_W-1:0] video_address;
      bit                            high_byte_next;
      bit                            row_step;
      bit                            horizontal;
      logic [vramp_pkg::DATA_W-1:0]  pattern_mem [vramp_pkg::PATTERN_BYTES];
      bit                            pattern_written [vramp_pkg::PATTERN_BYTES];
      logic [vramp_pkg::DATA_W-1:0]  nametable_mem [vramp_pkg::NAMETABLE_BYTES];
      bit                            nametable_written [vramp_pkg::NAMETABLE_BYTES];
      port_beat_type                 owed_beats [$];
      int                            errors;
      int                            checked;
      int                            func_count [4];

      function new();
         video_address  = '0;
         high_byte_next = 1'b1;
         row_step       = 1'b0;
         horizontal     = 1'b0;
         errors         = 0;
         checked        = 0;
         foreach (pattern_written[i]) pattern_written[i] = 1'b0;
         foreach (nametable_written[i]) nametable_written[i] = 1'b0;
         foreach (func_count[i]) func_count[i] = 0;
      endfunction

      function region_type region_of(logic [vramp_pkg::VADDR_W-1:0] a);
         if (a[15:13] == 3'b000) return REGION_PATTERN;
         if (a[15:12] == vramp_pkg::NT_TOP_NIBBLE) return REGION_NAMETABLE;
         return REGION_UNMAPPED;
      endfunction

      // Vertical mirroring picks the half with address bit 10, horizontal
      // with bit 11.
      function int nametable_slot(logic [vramp_pkg::VADDR_W-1:0] a);
         logic half;
         half = horizontal ? a[11] : a[10];
         return int'({half, a[9:0]});
      endfunction

      // A data read here is legal: either unmapped or a store entry that
      // was written before.
      function bit readable();
         case (region_of(video_address))
            REGION_PATTERN:   return pattern_written[video_address[12:0]];
            REGION_NAMETABLE:
               return nametable_written[nametable_slot(video_address)];
            default:          return 1'b1;
         endcase
      endfunction

      function void step_address();
         video_address = video_address +
                         (row_step ? vramp_pkg::STEP_ROW : vramp_pkg::STEP_COLUMN);
      endfunction

      function int pending();
         return owed_beats.size();
      endfunction

      function void note_request(vramp_pkg::func_type f,
                                 logic [vramp_pkg::DATA_W-1:0] d);
         port_beat_type beat;
         beat.read_data = '0;
         func_count[int'(f)]++;
         case (f)
            vramp_pkg::FUNC_CONTROL: row_step = d[vramp_pkg::CTRL_STEP_BIT];
            vramp_pkg::FUNC_ADDRESS: begin
               video_address &= vramp_pkg::VADDR_MASK;
               if (high_byte_next) video_address[15:8] = d;
               else video_address[7:0] = d;
               high_byte_next = !high_byte_next;
            end
            vramp_pkg::FUNC_WRITE: begin
               case (region_of(video_address))
                  REGION_PATTERN: begin
                     pattern_mem[video_address[12:0]]     = d;
                     pattern_written[video_address[12:0]] = 1'b1;
                  end
                  REGION_NAMETABLE: begin
                     nametable_mem[nametable_slot(video_address)]     = d;
                     nametable_written[nametable_slot(video_address)] = 1'b1;
                  end
                  default: ;
               endcase
               step_address();
            end
            default: begin
               case (region_of(video_address))
                  REGION_PATTERN:
                     beat.read_data = pattern_mem[video_address[12:0]];
                  REGION_NAMETABLE:
                     beat.read_data = nametable_mem[nametable_slot(video_address)];
                  default:
                     beat.read_data = '0;
               endcase
               step_address();
            end
         endcase
         beat.address = video_address;
         owed_beats.push_back(beat);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [vramp_pkg::DATA_W-1:0] rd,
                          logic [vramp_pkg::VADDR_W-1:0] addr);
         port_beat_type want;
         if (owed_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected response beat data=%h address=%h",
                                      rd, addr));
            return;
         end
         want = owed_beats.pop_front();
         checked++;
         if (rd !== want.read_data)
            report_mismatch($sformatf("beat %0d read_data %h, expected %h",
                                      checked, rd, want.read_data));
         if (addr !== want.address)
            report_mismatch($sformatf("beat %0d current_address %h, expected %h",
                                      checked, addr, want.address));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals. Every input of the block starts at a known value.
   // -------------------------------------------------------------------------
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_func = vramp_pkg::FUNC_CONTROL;
   logic [vramp_pkg::DATA_W-1:0]     req_data = '0;

   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [vramp_pkg::DATA_W-1:0]     rsp_read_data;
   logic [vramp_pkg::VADDR_W-1:0]    rsp_current_address;

   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [vramp_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                      pwdata = '0;
   logic [31:0]                      prdata;
   logic                             pready;

   vram_port_scoreboard              sb;

   // Idle and stall rates of the current phase, in percent of cycles.
   int                               send_idle_pct = 0;
   int                               rsp_stall_pct = 0;

   // The stimulus process bumps hold_requests to ask for a long receiver
   // hold-off; the receiver process serves it and counts the cycles itself.
   int                               hold_requests = 0;
   int                               hold_served = 0;
   int                               hold_left = 0;

   int                               beats_sent = 0;

   // Start addresses of recent write bursts, revisited later by reads.
   logic [vramp_pkg::VADDR_W-1:0]    recent_targets [$];

   video_ram_address_data_port DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_current_address (rsp_current_address),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Receiver. It stalls at the phase's rate, except while it serves a long
   // hold-off, during which the block has to fill up and stall its input.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Response monitor. Signals are sampled at the edge, before any update
   // that the edge itself causes, so a beat counts exactly when it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_read_data, rsp_current_address);
   end

   // -------------------------------------------------------------------------
   // Request driver. The caller is always just past a rising edge. Random
   // idle cycles come first. Then the beat is offered and held until the
   // block takes it. A data read of a store entry that was never written is
   // turned into a data write, so that reads only reach written entries.
   // -------------------------------------------------------------------------
   task automatic send(vramp_pkg::func_type f, logic [vramp_pkg::DATA_W-1:0] d);
      if (f == vramp_pkg::FUNC_READ && !sb.readable()) f = vramp_pkg::FUNC_WRITE;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      sb.note_request(f, d);
      beats_sent++;
   endtask

   // Drops valid and waits until every owed response beat has arrived.
   // At least one edge passes, so valid never gets two updates in one step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Loads the video address. The high-byte-first order masks the result to
   // 14 bits. The low-byte-first order leaves the high byte last and so
   // reaches any 16-bit address. One extra address write lines up the latch
   // when it points the wrong way.
   task automatic set_address(logic [vramp_pkg::VADDR_W-1:0] a);
      bit low_first;
      low_first = (a > vramp_pkg::VADDR_MASK) || ($urandom_range(1) == 1);
      if (sb.high_byte_next == low_first)
         send(vramp_pkg::FUNC_ADDRESS, 8'($urandom_range(255)));
      if (low_first) begin
         send(vramp_pkg::FUNC_ADDRESS, a[7:0]);
         send(vramp_pkg::FUNC_ADDRESS, a[15:8]);
      end else begin
         send(vramp_pkg::FUNC_ADDRESS, a[15:8]);
         send(vramp_pkg::FUNC_ADDRESS, a[7:0]);
      end
   endtask

   // Writes the mirroring register, then reads it back in the next transfer.
   // It is called only while the block is idle.
   task automatic write_mirroring(bit horiz);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MIRROR_ADDR;
      pwdata  <= 32'(horiz);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.horizontal = horiz;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(horiz))
         sb.report_mismatch($sformatf("mirroring register reads %h, expected %0d",
                                      prdata, horiz));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Most targets land in the two stores. The rest go to the unmapped window
   // above the nametable or anywhere in the 16-bit space.
   function automatic logic [vramp_pkg::VADDR_W-1:0] pick_target();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) return vramp_pkg::VADDR_W'($urandom_range(16'h1fff));
      if (sel < 80) return vramp_pkg::VADDR_W'(16'h2000 + $urandom_range(16'h0fff));
      if (sel < 90) return vramp_pkg::VADDR_W'(16'h3000 + $urandom_range(16'h0fff));
      return vramp_pkg::VADDR_W'($urandom_range(16'hffff));
   endfunction

   // One random sequence. Mostly a write burst that is read back from the
   // same start. Some sequences revisit an earlier burst with reads, and the
   // rest are loose beats of any kind.
   task automatic random_sequence();
      int unsigned                   pick;
      int unsigned                   burst;
      logic [vramp_pkg::VADDR_W-1:0] target;
      pick = $urandom_range(99);
      if (pick < 60) begin
         target = pick_target();
         if ($urandom_range(1) == 1)
            send(vramp_pkg::FUNC_CONTROL, 8'($urandom_range(255)));
         burst = $urandom_range(1, 8);
         set_address(target);
         repeat (burst) send(vramp_pkg::FUNC_WRITE, 8'($urandom_range(255)));
         set_address(target);
         repeat (burst) send(vramp_pkg::FUNC_READ, 8'($urandom_range(255)));
         recent_targets.push_back(target);
         if (recent_targets.size() > 32) void'(recent_targets.pop_front());
      end else if (pick < 75 && recent_targets.size() != 0) begin
         target = recent_targets[$urandom_range(recent_targets.size() - 1)];
         set_address(target);
         repeat ($urandom_range(1, 4))
            send(vramp_pkg::FUNC_READ, 8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 4))
            send(vramp_pkg::func_type'($urandom_range(3)), 8'($urandom_range(255)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      int  phase_start;
      bit  paused;
      sb = new();
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed beats, with the reset mirroring mode (vertical) and no idling.
      // The control byte has every bit set except the step select.
      send(vramp_pkg::FUNC_CONTROL, 8'hfb);
      // A high byte of 0xFF leaves the address far above 14 bits. Reads there
      // return 0, and writes there are dropped, yet the address still steps.
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_READ,    8'h00);
      send(vramp_pkg::FUNC_WRITE,   8'haa);
      // The low byte write masks the address back to 14 bits: 0x3FFF.
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_WRITE,   8'h55);
      // Last pattern byte, then the first nametable byte.
      send(vramp_pkg::FUNC_ADDRESS, 8'h1f);
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_WRITE,   8'h12);
      send(vramp_pkg::FUNC_WRITE,   8'h34);
      // Row step, last nametable byte, then a read in the unmapped window.
      send(vramp_pkg::FUNC_CONTROL, 8'h04);
      send(vramp_pkg::FUNC_ADDRESS, 8'h2f);
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_WRITE,   8'h56);
      send(vramp_pkg::FUNC_READ,    8'hff);
      send(vramp_pkg::FUNC_ADDRESS, 8'h00);
      send(vramp_pkg::FUNC_ADDRESS, 8'h00);
      send(vramp_pkg::FUNC_WRITE,   8'hff);
      // Column step again, and read back across the store boundary.
      send(vramp_pkg::FUNC_CONTROL, 8'h00);
      send(vramp_pkg::FUNC_ADDRESS, 8'h1f);
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_READ,    8'h00);
      send(vramp_pkg::FUNC_READ,    8'h00);
      // Three address writes of 0xFF end on the high byte and leave 0xFFFF.
      // A read there wraps the address to zero.
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_ADDRESS, 8'hff);
      send(vramp_pkg::FUNC_READ,    8'h00);

      // Random phases: no idling; sender idle; receiver stalling, with a long
      // hold-off; both idling a little, with one pause of the sender until
      // everything has drained. Mirroring alternates between the two modes.
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_mirroring(p % 2 == 0);
         case (p)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 49; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 49; end
            default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         if (p == 2) hold_requests++;
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            random_sequence();
            if (p == 3 && !paused && beats_sent - phase_start >= PHASE_BEATS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      // Let everything owed come out, then watch a little longer for extras.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d response beats never arrived", sb.pending()));

      $display("Covered %0d request beats: %0d control, %0d address, %0d data write,",
               beats_sent, sb.func_count[vramp_pkg::FUNC_CONTROL],
               sb.func_count[vramp_pkg::FUNC_ADDRESS],
               sb.func_count[vramp_pkg::FUNC_WRITE]);
      $display("%0d data read; checked %0d response beats, both mirroring modes, %s%0d%s",
               sb.func_count[vramp_pkg::FUNC_READ], sb.checked,
               "both steps and a ", LONG_HOLD_CYCLES, "-cycle hold-off.");
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Safety net in case the block stops moving.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout: run did not complete, %0d beats still owed.", sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ files.f @@
sv/vramp_pkg.sv
sv/vramp_ram.sv
sv/vramp_mem.sv
sv/video_ram_address_data_port.sv
tb/video_ram_address_data_port_test.sv
